/* hdl/cms3_pkg.sv */
// ----------------------------------------------------------------------------
// cms3_pkg: shared types and constants of the three-row count-min sketch
// Hash widths, seeds, remainder stepping, state encoding and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cms3_pkg;

    localparam int DEF_TABLE_SIZE  = 457;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam int KEY_W  = 8;
    localparam int EST_W  = 32;
    localparam int HASH_W = 64;

    localparam logic [HASH_W-1:0] SEED_SX  = '0;
    localparam logic [HASH_W-1:0] SEED_H33 = HASH_W'(5381);
    localparam logic [HASH_W-1:0] SEED_H31 = '0;

    localparam int SX_LSH = 2;
    localparam int SX_RSH = 14;
    localparam int MUL_SH = 5;   // 33 = 32 + 1, 31 = 32 - 1

    // remainder unit: byte fold, reciprocal quotient, correction
    localparam int DIV_CYCLES = 3;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam int ROWS = 3;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_HASH,
        ST_DIV,
        ST_READ,
        ST_UPDATE
    } cms3_state_t;

    typedef struct packed {
        logic clear_step;
        logic byte_take;
        logic key_end;
        logic div_step;
        logic rd_en;
        logic wr_en;
        logic out_load;
    } cms3_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic op_query;
        logic out_full;
    } cms3_sts_t;

endpackage

/* hdl/count_min_sketch_three_hash.sv */
// ----------------------------------------------------------------------------
// count_min_sketch_three_hash: three-row count-min sketch
// Top level: joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
// A key arrives on the s_axis channel one byte per word: tdata carries the
// byte, tlast marks the final byte, tuser carries the op (0 store, 1 query)
// and is looked at only with tlast. Zero bytes are skipped inside a key.
// Bytes before the last are taken back to back. The last byte starts a
// remainder computation for all three rows (fold the 64-bit hash by
// bytes, reciprocal quotient, correct the remainder), then reads the
// counter rows and updates them or loads the result: s_axis_tready stays
// low after the last byte until the update step is done, and the result
// word appears on m_axis in the same cycle that s_axis_tready returns.
// A store gives no word; a query gives one word with the smallest of the
// three selected counters.
// After reset the counter rows are cleared one entry per cycle, with
// s_axis_tready low. When the receiver stalls, a pending result holds in
// the output register; key bytes are still taken, and the next query
// waits before its update step until the register is free.
// ----------------------------------------------------------------------------
module count_min_sketch_three_hash #(
    parameter int TABLE_SIZE  = cms3_pkg::DEF_TABLE_SIZE,
    parameter int COUNT_WIDTH = cms3_pkg::DEF_COUNT_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [cms3_pkg::KEY_W-1:0] s_axis_tdata,   // [7:0] key_byte
    input  logic                       s_axis_tuser,   // [0] op
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [cms3_pkg::EST_W-1:0] m_axis_tdata    // [31:0] estimate
);

    import cms3_pkg::*;

    cms3_cmd_t cmd;
    cms3_sts_t sts;

    cms3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cms3_dp #(
        .TABLE_SIZE  (TABLE_SIZE),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_op        (s_axis_tuser),
        .in_key_byte  (s_axis_tdata),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_estimate (m_axis_tdata)
    );

endmodule

/* hdl/cms3_ram.sv */
// ----------------------------------------------------------------------------
// cms3_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered on rd_en.
// ----------------------------------------------------------------------------
module cms3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 457
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/cms3_ctrl.sv */
// ----------------------------------------------------------------------------
// cms3_ctrl: sequencer of the count-min sketch
// Clears the counter rows after reset, takes key bytes, then walks the
// remainder unit, the counter read and the update or result.
// ----------------------------------------------------------------------------
module cms3_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  cms3_pkg::cms3_sts_t sts,
    output cms3_pkg::cms3_cmd_t cmd
);

    import cms3_pkg::*;

    cms3_state_t state_reg;
    cms3_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // a query waits here until the output register frees up
                if (!sts.op_query || !sts.out_full)
                begin
                    state_next = ST_HASH;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_HASH:
            begin
                in_ready      = 1'b1;
                cmd.byte_take = in_valid;
                cmd.key_end   = in_valid && in_last;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.wr_en    = !sts.op_query;
                cmd.out_load = sts.op_query && !sts.out_full;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/cms3_dp.sv */
// ----------------------------------------------------------------------------
// cms3_dp: datapath of the count-min sketch
// Running hashes, a three-step fold and reciprocal remainder unit per row,
// the three counter rows, saturating increment, minimum and the result
// register.
// ----------------------------------------------------------------------------
module cms3_dp #(
    parameter int TABLE_SIZE  = cms3_pkg::DEF_TABLE_SIZE,
    parameter int COUNT_WIDTH = cms3_pkg::DEF_COUNT_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cms3_pkg::cms3_cmd_t         cmd,
    output cms3_pkg::cms3_sts_t         sts,
    input  logic                        in_op,
    input  logic [cms3_pkg::KEY_W-1:0]  in_key_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [cms3_pkg::EST_W-1:0]  out_estimate
);

    import cms3_pkg::*;

    localparam int AW     = $clog2(TABLE_SIZE);
    localparam int NBYTES = HASH_W / 8;
    // eight terms of byte times weight, each below 2^(AW+8)
    localparam int FOLD_W = AW + 11;
    localparam logic [FOLD_W-1:0] FOLD_N = FOLD_W'(TABLE_SIZE);
    localparam longint unsigned RECIP_L = (64'd1 << FOLD_W) / TABLE_SIZE;
    localparam logic [FOLD_W-1:0] RECIP = FOLD_W'(RECIP_L);
    localparam logic [AW-1:0] ADDR_LAST = AW'(TABLE_SIZE - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // weight of hash byte i: 2^(8i) mod TABLE_SIZE
    function automatic logic [NBYTES*AW-1:0] byte_weights();
        logic [NBYTES*AW-1:0] ws;
        longint unsigned      w;
        ws = '0;
        w  = 1;
        for (int i = 0; i < NBYTES; i++)
        begin
            ws[AW*i +: AW] = AW'(w % TABLE_SIZE);
            w = (w * 256) % TABLE_SIZE;
        end
        return ws;
    endfunction

    localparam logic [NBYTES*AW-1:0] BYTE_WEIGHTS = byte_weights();

    // congruent to the hash modulo TABLE_SIZE, but only FOLD_W bits wide
    function automatic logic [FOLD_W-1:0] fold_hash(input logic [HASH_W-1:0] h);
        logic [FOLD_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < NBYTES; i++)
        begin
            acc = acc + FOLD_W'(h[8*i +: 8]) * FOLD_W'(BYTE_WEIGHTS[AW*i +: AW]);
        end
        return acc;
    endfunction

    logic [HASH_W-1:0] sx_reg, h33_reg, h31_reg;
    logic [HASH_W-1:0] sx_new, h33_new, h31_new;
    logic [HASH_W-1:0] byte_ext;
    logic              byte_nz;

    logic [HASH_W-1:0]    hash_hold_reg [ROWS];
    logic [HASH_W-1:0]    quo_load [ROWS];
    logic [FOLD_W-1:0]    fold_reg [ROWS];
    logic [FOLD_W-1:0]    quo_reg [ROWS];
    logic [AW-1:0]        rem_reg [ROWS];
    logic [2*FOLD_W-1:0]  quo_prod [ROWS];
    logic [FOLD_W-1:0]    rem_wide [ROWS];
    logic [AW-1:0]        rem_fix [ROWS];
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 op_reg;
    logic [AW-1:0]        clr_addr_reg;

    logic [COUNT_WIDTH-1:0] rd_data [ROWS];
    logic [COUNT_WIDTH-1:0] min01, min_all;
    logic [EST_W-1:0]       est_next;
    logic [EST_W-1:0]       est_reg;
    logic                   out_valid_reg;

    assign byte_nz  = |in_key_byte;
    assign byte_ext = {{(HASH_W-KEY_W){in_key_byte[KEY_W-1]}}, in_key_byte};

    // a zero byte leaves the hashes alone
    always_comb
    begin
        sx_new  = sx_reg;
        h33_new = h33_reg;
        h31_new = h31_reg;
        if (byte_nz)
        begin
            sx_new  = (sx_reg << SX_LSH) ^ (sx_reg >> SX_RSH) ^ byte_ext;
            h33_new = (h33_reg << MUL_SH) + h33_reg + byte_ext;
            h31_new = (h31_reg << MUL_SH) - h31_reg + byte_ext;
        end
    end

    assign quo_load[0] = sx_new;
    assign quo_load[1] = h33_new;
    assign quo_load[2] = h31_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg  <= SEED_SX;
            h33_reg <= SEED_H33;
            h31_reg <= SEED_H31;
        end
        else if (cmd.key_end)
        begin
            sx_reg  <= SEED_SX;
            h33_reg <= SEED_H33;
            h31_reg <= SEED_H31;
        end
        else if (cmd.byte_take)
        begin
            sx_reg  <= sx_new;
            h33_reg <= h33_new;
            h31_reg <= h31_new;
        end
    end

    // quotient estimate is exact or one low, so one subtract finishes it
    always_comb
    begin
        for (int k = 0; k < ROWS; k++)
        begin
            quo_prod[k] = (2*FOLD_W)'(fold_reg[k]) * (2*FOLD_W)'(RECIP);
            rem_wide[k] = fold_reg[k] - quo_reg[k] * FOLD_N;
            rem_fix[k]  = (rem_wide[k] >= FOLD_N) ? AW'(rem_wide[k] - FOLD_N)
                                                  : AW'(rem_wide[k]);
        end
    end

    // remainder unit: fold, quotient, remainder advance one stage per step
    always_ff @(posedge clk)
    begin
        if (cmd.key_end)
        begin
            op_reg <= in_op;
        end
        for (int k = 0; k < ROWS; k++)
        begin
            if (cmd.key_end)
            begin
                hash_hold_reg[k] <= quo_load[k];
            end
            else if (cmd.div_step)
            begin
                fold_reg[k] <= fold_hash(hash_hold_reg[k]);
                quo_reg[k]  <= quo_prod[k][2*FOLD_W-1 -: FOLD_W];
                rem_reg[k]  <= rem_fix[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg  <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.key_end)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // counter rows
    for (genvar k = 0; k < ROWS; k++)
    begin : g_row
        logic [AW-1:0]          wr_addr;
        logic [COUNT_WIDTH-1:0] wr_data;

        always_comb
        begin
            if (cmd.clear_step)
            begin
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            else
            begin
                wr_addr = rem_reg[k];
                // saturate at the top
                wr_data = (rd_data[k] == COUNT_MAX) ? rd_data[k] : rd_data[k] + 1'b1;
            end
        end

        cms3_ram #(
            .WIDTH (COUNT_WIDTH),
            .DEPTH (TABLE_SIZE)
        ) u_ram (
            .clk     (clk),
            .wr_en   (cmd.clear_step || cmd.wr_en),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_en   (cmd.rd_en),
            .rd_addr (rem_reg[k]),
            .rd_data (rd_data[k])
        );
    end

    assign min01   = (rd_data[1] < rd_data[0]) ? rd_data[1] : rd_data[0];
    assign min_all = (rd_data[2] < min01) ? rd_data[2] : min01;

    if (COUNT_WIDTH < EST_W)
    begin : g_est_narrow
        assign est_next = {{(EST_W-COUNT_WIDTH){1'b0}}, min_all};
    end
    else if (COUNT_WIDTH == EST_W)
    begin : g_est_equal
        assign est_next = min_all;
    end
    else
    begin : g_est_wide
        assign est_next = (|min_all[COUNT_WIDTH-1:EST_W]) ? '1 : min_all[EST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            est_reg <= est_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_estimate = est_reg;

    assign sts.clr_last = (clr_addr_reg == ADDR_LAST);
    assign sts.div_last = (div_cnt_reg == DIV_CNT_LAST);
    assign sts.op_query = (op_reg == OP_QUERY);
    assign sts.out_full = out_valid_reg && !out_ready;

endmodule

/* hdl/cms3_chk.sv */
// ----------------------------------------------------------------------------
// cms3_chk: port-level checks of the count-min sketch
// Watches the top level's stream ports; attached by bind.
// ----------------------------------------------------------------------------
module cms3_chk (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [cms3_pkg::KEY_W-1:0] s_axis_tdata,
    input logic                       s_axis_tuser,
    input logic                       s_axis_tlast,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [cms3_pkg::EST_W-1:0] m_axis_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // the last byte of a key starts the hash reduction: input goes busy
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready right after last byte");

    // bytes inside a key are taken back to back
    a_ready_in_key: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
        else $error("input stalled inside a key");

    // a result is loaded only from the update step, while input is busy
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a finished query");

endmodule

bind count_min_sketch_three_hash cms3_chk u_cms3_chk (.*);
